/* src/fism_pkg.sv */
// Shared types and constants for the frame interval statistics monitor.
`default_nettype none
package fism_pkg;

  localparam int SlotsDef   = 4;
  localparam int SrcW       = 32;
  localparam int TsW        = 63;
  localparam int RateW      = 40;
  localparam int UsW        = 32;
  localparam int CntW       = 16;
  localparam int SumW       = 48;
  localparam int ScaleW     = 20;
  localparam int ProdW      = TsW + ScaleW;
  localparam int InDataW    = 96;
  localparam int OutDataW   = 208;

  localparam logic [ScaleW-1:0] UsScale  = 20'd1000000;
  localparam logic [ScaleW-1:0] MsScale  = 20'd1000;
  localparam logic [ScaleW-1:0] OneScale = 20'd1;

  // Register indexes on the configuration port
  localparam logic [2:0] RegTickRate  = 3'd0;
  localparam logic [2:0] RegStallThr  = 3'd1;
  localparam logic [2:0] RegDoubleThr = 3'd2;
  localparam logic [2:0] RegSpikeThr  = 3'd3;
  localparam logic [2:0] RegSpikeGap  = 3'd4;
  localparam logic [2:0] RegWindowLen = 3'd5;

  typedef struct packed {
    logic [SrcW-1:0] source_id;
    logic [TsW-1:0]  timestamp;
    logic            zero_src;
  } event_t;

  typedef struct packed {
    logic [RateW-1:0]  tick_rate;
    logic [UsW-1:0]    stall_threshold_us;
    logic [UsW-1:0]    double_threshold_us;
    logic [UsW-1:0]    spike_threshold_us;
    logic [CntW-1:0]   spike_gap_ms;
    logic [CntW-1:0]   window_len;
  } cfg_t;

  // sat high: clamp the quotient to 32 bits; low: keep its low 32 bits
  typedef struct packed {
    logic              start;
    logic              sat;
    logic [TsW-1:0]    a;
    logic [ScaleW-1:0] scale;
    logic [RateW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [UsW-1:0] q;
  } div_rsp_t;

endpackage
`default_nettype wire

/* src/fism_front.sv */
// Front end: accepts present events, flags reserved ids, queues them for the back end.
`default_nettype none
module fism_front import fism_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SrcW-1:0]    in_source_id,
  input  wire logic [TsW-1:0]     in_timestamp,
  output logic                    q_valid,
  output event_t                  q_data,
  input  wire logic               q_pop
);

  event_t     fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_data   = fifo[rd_ptr];

  // Store entries with the reserved-id mark
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{source_id: in_source_id, timestamp: in_timestamp,
                        zero_src: (in_source_id == '0)};
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/fism_div.sv */
// Shared scale-and-divide unit: floor(a * scale / den), saturated to 32 bits if sat.
`default_nettype none
module fism_div import fism_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV} phase_t;

  phase_t             phase;
  logic [6:0]         cnt;
  logic [TsW-1:0]     a;
  logic [ScaleW-1:0]  scale;
  logic [RateW-1:0]   den;
  logic               sat;
  logic [ProdW-1:0]   prod;
  logic [RateW-1:0]   rem;
  logic [UsW-1:0]     quo;
  logic               ovf;
  logic [UsW-1:0]     q;
  logic               done;
  logic [RateW:0]     rem_sh;
  logic               ge;
  logic [RateW:0]     rem_sub;

  assign rem_sh  = {rem, prod[ProdW-1]};
  assign ge      = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};

  assign rsp.busy = (phase != PH_IDLE);
  assign rsp.done = done;
  assign rsp.q    = q;

  // Multiply MSB first by shift-add, then restoring division one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (req.start) begin
            a     <= req.a;
            scale <= req.scale;
            den   <= req.den;
            sat   <= req.sat;
            prod  <= '0;
            cnt   <= '0;
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          prod  <= {prod[ProdW-2:0], 1'b0} +
                   (scale[ScaleW-1] ? {{ScaleW{1'b0}}, a} : '0);
          scale <= {scale[ScaleW-2:0], 1'b0};
          if (cnt == 7'(ScaleW - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            quo   <= '0;
            ovf   <= 1'b0;
            phase <= PH_DIV;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        PH_DIV: begin
          prod <= {prod[ProdW-2:0], 1'b0};
          rem  <= ge ? rem_sub[RateW-1:0] : rem_sh[RateW-1:0];
          quo  <= {quo[UsW-2:0], ge};
          ovf  <= ovf | quo[UsW-1];
          if (cnt == 7'(ProdW - 1)) begin
            q     <= (sat && (ovf || quo[UsW-1])) ? '1 : {quo[UsW-2:0], ge};
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/fism_back.sv */
// Back end: slot table, interval statistics, spike limiting, window records, result register.
`default_nettype none
module fism_back import fism_pkg::*; #(
  parameter int SLOTS = SlotsDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               q_valid,
  input  wire event_t             q_data,
  output logic                    q_pop,
  output div_req_t                div_req,
  input  wire div_rsp_t           div_rsp,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_kind,
  output logic                    out_last,
  output logic [OutDataW-1:0]     out_data
);

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_HIT, ST_WAIT_US, ST_WAIT_SPK, ST_WIN,
    ST_SPK_OUT, ST_REC_NEXT, ST_AVG_WAIT, ST_REC_OUT
  } state_t;

  state_t state;

  logic [SrcW-1:0]  slot_source    [SLOTS];
  logic [TsW-1:0]   slot_last_time [SLOTS];
  logic [CntW-1:0]  slot_frames    [SLOTS];
  logic [SumW-1:0]  slot_sum_us    [SLOTS];
  logic [UsW-1:0]   slot_max_us    [SLOTS];
  logic [UsW-1:0]   slot_min_us    [SLOTS];
  logic [CntW-1:0]  slot_stalls    [SLOTS];
  logic [CntW-1:0]  slot_doubles   [SLOTS];
  logic [CntW-1:0]  window_count;
  logic [TsW-1:0]   last_spike_time;

  logic [SrcW-1:0]  src;
  logic [TsW-1:0]   now;
  logic             zero_src;
  logic [SlotW-1:0] idx;
  logic             spike;
  logic [UsW-1:0]   spike_val;
  logic [UsW-1:0]   avg;
  logic [SLOTS-1:0] mask;

  logic             hit_c;
  logic             free_c;
  logic [SlotW-1:0] hit_idx_c;
  logic [SlotW-1:0] free_idx_c;
  logic [SLOTS-1:0] active_c;
  logic [SlotW-1:0] low_c;
  logic [SLOTS-1:0] mask_rest_c;
  logic [CntW-1:0]  wc_inc;
  logic [SumW:0]    sum_add;
  logic             out_free;
  logic [UsW-1:0]   us_c;

  assign out_free = !out_valid || out_ready;
  assign wc_inc   = window_count + 16'd1;
  assign us_c     = div_rsp.q;
  assign sum_add  = {1'b0, slot_sum_us[idx]} + {{(SumW + 1 - UsW){1'b0}}, us_c};
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // Search table for a match and the lowest free slot
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_source[i] == src) begin
        hit_c     = 1'b1;
        hit_idx_c = SlotW'(i);
      end
      if (slot_source[i] == '0) begin
        free_c     = 1'b1;
        free_idx_c = SlotW'(i);
      end
    end
  end

  // Slots that own a record when a window closes
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      active_c[i] = (slot_source[i] != '0) && (slot_frames[i] != '0);
    end
  end

  // Lowest pending record slot
  always_comb begin
    low_c = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) low_c = SlotW'(i);
    end
    mask_rest_c = mask & ~(SLOTS'(1) << low_c);
  end

  // Sequencer, slot table and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      window_count    <= '0;
      last_spike_time <= '0;
      out_valid       <= 1'b0;
      spike           <= 1'b0;
      mask            <= '0;
      div_req         <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_source[i]    <= '0;
        slot_last_time[i] <= '0;
        slot_frames[i]    <= '0;
        slot_sum_us[i]    <= '0;
        slot_max_us[i]    <= '0;
        slot_min_us[i]    <= '1;
        slot_stalls[i]    <= '0;
        slot_doubles[i]   <= '0;
      end
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            src      <= q_data.source_id;
            now      <= q_data.timestamp;
            zero_src <= q_data.zero_src;
            state    <= ST_LOOK;
          end
        end

        // Move on to the owner or claim a free slot; reserved ids and a full table skip ahead
        ST_LOOK: begin
          if (zero_src) begin
            state <= ST_WIN;
          end else if (hit_c) begin
            idx   <= hit_idx_c;
            state <= ST_HIT;
          end else if (free_c) begin
            slot_source[free_idx_c]    <= src;
            slot_last_time[free_idx_c] <= now;
            slot_frames[free_idx_c]    <= '0;
            slot_sum_us[free_idx_c]    <= '0;
            slot_max_us[free_idx_c]    <= '0;
            slot_min_us[free_idx_c]    <= '1;
            slot_stalls[free_idx_c]    <= '0;
            slot_doubles[free_idx_c]   <= '0;
            state <= ST_WIN;
          end else begin
            state <= ST_WIN;
          end
        end

        // Start interval conversion when time moved forward and the tick rate is nonzero
        ST_HIT: begin
          slot_last_time[idx] <= now;
          if (now > slot_last_time[idx] && cfg.tick_rate != '0) begin
            div_req <= '{start: 1'b1, sat: 1'b1, a: now - slot_last_time[idx],
                         scale: UsScale, den: cfg.tick_rate};
            state   <= ST_WAIT_US;
          end else begin
            state <= ST_WIN;
          end
        end

        // Count the interval; check spike threshold
        ST_WAIT_US: begin
          if (div_rsp.done) begin
            spike_val <= us_c;
            if (slot_frames[idx] != '1) slot_frames[idx] <= slot_frames[idx] + 16'd1;
            slot_sum_us[idx] <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
            if (us_c > slot_max_us[idx]) slot_max_us[idx] <= us_c;
            if (us_c < slot_min_us[idx]) slot_min_us[idx] <= us_c;
            if (us_c > cfg.stall_threshold_us && slot_stalls[idx] != '1)
              slot_stalls[idx] <= slot_stalls[idx] + 16'd1;
            if (us_c < cfg.double_threshold_us && slot_doubles[idx] != '1)
              slot_doubles[idx] <= slot_doubles[idx] + 16'd1;
            if (us_c > cfg.spike_threshold_us && now >= last_spike_time) begin
              div_req <= '{start: 1'b1, sat: 1'b1, a: now - last_spike_time,
                           scale: MsScale, den: cfg.tick_rate};
              state   <= ST_WAIT_SPK;
            end else begin
              state <= ST_WIN;
            end
          end
        end

        // Rate-limit spike reports by elapsed milliseconds
        ST_WAIT_SPK: begin
          if (div_rsp.done) begin
            if (us_c > {{(UsW - CntW){1'b0}}, cfg.spike_gap_ms}) begin
              spike           <= 1'b1;
              last_spike_time <= now;
            end
            state <= ST_WIN;
          end
        end

        // Close the window when the count reaches its length
        ST_WIN: begin
          if (wc_inc >= cfg.window_len) begin
            window_count <= '0;
            mask         <= active_c;
          end else begin
            window_count <= wc_inc;
            mask         <= '0;
          end
          state <= spike ? ST_SPK_OUT : ST_REC_NEXT;
        end

        ST_SPK_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= 1'b0;
            out_last  <= (mask == '0);
            out_data  <= {spike_val, {(OutDataW - UsW - SrcW){1'b0}}, src};
            spike     <= 1'b0;
            state     <= ST_REC_NEXT;
          end
        end

        // Average the next pending slot
        ST_REC_NEXT: begin
          if (mask == '0) begin
            state <= ST_IDLE;
          end else begin
            idx     <= low_c;
            div_req <= '{start: 1'b1,
                         sat: 1'b0,
                         a: {{(TsW - SumW){1'b0}}, slot_sum_us[low_c]},
                         scale: OneScale,
                         den: {{(RateW - CntW){1'b0}}, slot_frames[low_c]}};
            state   <= ST_AVG_WAIT;
          end
        end

        ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            avg   <= us_c;
            state <= ST_REC_OUT;
          end
        end

        // Emit the record and clear the slot statistics
        ST_REC_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= 1'b1;
            out_last  <= (mask_rest_c == '0);
            out_data  <= {{UsW{1'b0}}, slot_doubles[idx], slot_stalls[idx],
                          slot_max_us[idx], slot_min_us[idx], avg,
                          slot_frames[idx], slot_source[idx]};
            slot_frames[idx]  <= '0;
            slot_sum_us[idx]  <= '0;
            slot_max_us[idx]  <= '0;
            slot_min_us[idx]  <= '1;
            slot_stalls[idx]  <= '0;
            slot_doubles[idx] <= '0;
            mask  <= mask & ~(SLOTS'(1) << idx);
            state <= ST_REC_NEXT;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pending records only ever name active slots
  assert property (@(posedge clk) disable iff (rst) (mask & ~active_c) == '0)
    else $error("record pending for an inactive slot");

  // Divider results arrive only while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_WAIT_US || state == ST_WAIT_SPK ||
                      state == ST_AVG_WAIT))
    else $error("divider result arrived outside a wait state");

  // No new event is taken while the divider is still running
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !div_rsp.busy)
    else $error("event taken with divider busy");

endmodule
`default_nettype wire

/* src/frame_interval_stats_monitor_core.sv */
// Top level: configuration registers, event front end, shared divider and back end.
`default_nettype none
// Present events (source id, tick timestamp) enter through s_axis and wait in a
// two-entry queue; results leave through m_axis from a single output register.
// Events are processed one at a time by a sequencer that shares one
// scale-and-divide unit (20 multiply steps, then 83 divide steps). A new source
// or a dropped event does not use it; a counted interval uses it once, twice when
// a spike check runs; each window record uses it once more, plus any wait for
// m_axis to drain. Registers sit on a 64-bit APB port at byte address 8*index;
// no clearing pass after reset.
module frame_interval_stats_monitor_core import fism_pkg::*; #(
  parameter int SLOTS = SlotsDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [31:0] source_id, [94:32] timestamp, [95] unused
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [31:0] source_id_res, [47:32] frames, [79:48] avg_us, [111:80] min_us,
  // [143:112] max_us, [159:144] stall_count, [175:160] double_count,
  // [207:176] spike interval
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [0] kind
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [5:0]          paddr,
  input  wire logic [63:0]         pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);

  cfg_t     cfg;
  logic     q_valid;
  event_t   q_data;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_rate           <= 40'd10000000;
      cfg.stall_threshold_us  <= 32'd25000;
      cfg.double_threshold_us <= 32'd8000;
      cfg.spike_threshold_us  <= 32'd33000;
      cfg.spike_gap_ms        <= 16'd100;
      cfg.window_len          <= 16'd300;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        RegTickRate:  cfg.tick_rate           <= pwdata[RateW-1:0];
        RegStallThr:  cfg.stall_threshold_us  <= pwdata[UsW-1:0];
        RegDoubleThr: cfg.double_threshold_us <= pwdata[UsW-1:0];
        RegSpikeThr:  cfg.spike_threshold_us  <= pwdata[UsW-1:0];
        RegSpikeGap:  cfg.spike_gap_ms        <= pwdata[CntW-1:0];
        RegWindowLen: cfg.window_len          <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    unique case (paddr[5:3])
      RegTickRate:  prdata = {{(64 - RateW){1'b0}}, cfg.tick_rate};
      RegStallThr:  prdata = {{(64 - UsW){1'b0}}, cfg.stall_threshold_us};
      RegDoubleThr: prdata = {{(64 - UsW){1'b0}}, cfg.double_threshold_us};
      RegSpikeThr:  prdata = {{(64 - UsW){1'b0}}, cfg.spike_threshold_us};
      RegSpikeGap:  prdata = {{(64 - CntW){1'b0}}, cfg.spike_gap_ms};
      RegWindowLen: prdata = {{(64 - CntW){1'b0}}, cfg.window_len};
      default:      prdata = '0;
    endcase
  end

  fism_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_source_id (s_axis_tdata[SrcW-1:0]),
    .in_timestamp (s_axis_tdata[SrcW+TsW-1:SrcW]),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  fism_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fism_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire
